// ----- rtl/core/puv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path validator package
// Shared constants, register map and path state type of the path validator.
// ----------------------------------------------------------------------------
package puv_pkg;

	localparam int unsigned MAX_PATH   = 128;
	localparam int unsigned BYTE_CNT_W = $clog2(MAX_PATH + 1);

	// Register map: one 32-bit register every four bytes.
	localparam int unsigned NUM_REGS = 2;
	localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);
	localparam int unsigned ADDR_W   = REG_IDX_W + 2;
	localparam logic [REG_IDX_W-1:0] REG_SEGMENT_LIMIT = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_DEPTH_LIMIT   = REG_IDX_W'(1);

	localparam logic [7:0] SEGMENT_LIMIT_RESET = 8'd64;
	localparam logic [7:0] DEPTH_LIMIT_RESET   = 8'd8;

	// Byte codes and UTF-8 bounds.
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_SLASH = 8'h2f;
	localparam logic [7:0] CHAR_DOT   = 8'h2e;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_DEL   = 8'h7f;
	localparam logic [7:0] LEAD2_LO   = 8'hc2;
	localparam logic [7:0] LEAD2_HI   = 8'hdf;
	localparam logic [7:0] LEAD3_LO   = 8'he0;
	localparam logic [7:0] LEAD3_HI   = 8'hef;
	localparam logic [7:0] LEAD4_LO   = 8'hf0;
	localparam logic [7:0] LEAD4_HI   = 8'hf4;
	localparam logic [20:0] CP_MIN3   = 21'h000800;
	localparam logic [20:0] CP_MIN4   = 21'h010000;
	localparam logic [20:0] CP_SUR_LO = 21'h00d800;
	localparam logic [20:0] CP_SUR_HI = 21'h00dfff;
	localparam logic [20:0] CP_MAX    = 21'h10ffff;
	localparam logic [7:0]  CNT_MAX   = 8'hff;

	typedef struct packed {
		logic [7:0] segment_limit;
		logic [7:0] depth_limit;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_CNT_W-1:0] byte_count;
		logic [7:0]            segment_count;
		logic [7:0]            depth_count;
		logic [1:0]            pending;
		logic [1:0]            seq_len;
		logic [20:0]           codepoint;
		logic [1:0]            dot_flags;
		logic                  failed;
	} path_state_t;

	localparam path_state_t PATH_STATE_CLEAR = '0;

endpackage

// ----- rtl/core/puv_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path validator channels
// Valid/ready channels for path bytes and for verdicts.
// ----------------------------------------------------------------------------
interface puv_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] path_byte;

	modport source (output valid, output path_byte, input ready);
	modport sink (input valid, input path_byte, output ready);
endinterface

interface puv_verdict_if;
	logic valid;
	logic ready;
	logic path_valid;

	modport source (output valid, output path_valid, input ready);
	modport sink (input valid, input path_valid, output ready);
endinterface

// ----- rtl/core/puv_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path validator configuration registers
// APB-style register file holding the segment and depth limits.
// ----------------------------------------------------------------------------
module puv_cfg
	import puv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.segment_limit <= SEGMENT_LIMIT_RESET;
			cfg_q.depth_limit   <= DEPTH_LIMIT_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SEGMENT_LIMIT: cfg_q.segment_limit <= pwdata[7:0];
				REG_DEPTH_LIMIT:   cfg_q.depth_limit   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SEGMENT_LIMIT: prdata = {24'd0, cfg_q.segment_limit};
			REG_DEPTH_LIMIT:   prdata = {24'd0, cfg_q.depth_limit};
			default:           prdata = 32'd0;
		endcase
	end

endmodule

// ----- rtl/core/puv_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path validator byte step
// Next path state and verdict for one path byte.
// ----------------------------------------------------------------------------
module puv_step
	import puv_pkg::*;
(
	input  cfg_t        cfg,
	input  path_state_t cur,
	input  logic [7:0]  path_byte,
	output path_state_t nxt,
	output logic        verdict
);

	logic        close_fail;
	logic [7:0]  depth_inc;
	logic        depth_sat;
	logic [7:0]  seg_inc;
	logic        seg_sat;
	logic [20:0] cp_next;
	logic [1:0]  pend_dec;
	logic        cp_bad;
	logic [BYTE_CNT_W:0] count_plus;

	// Segment close checks, shared by the slash and the terminator.
	always_comb begin
		depth_sat = (cur.depth_count == CNT_MAX);
		depth_inc = depth_sat ? CNT_MAX : cur.depth_count + 8'd1;
		close_fail = (cur.segment_count == 8'd0)
			|| (cur.segment_count > cfg.segment_limit)
			|| (cur.segment_count == 8'd1 && cur.dot_flags[0])
			|| (cur.segment_count == 8'd2 && cur.dot_flags == 2'b11)
			|| depth_sat
			|| (depth_inc > cfg.depth_limit);
	end

	always_comb begin
		seg_sat  = (cur.segment_count == CNT_MAX);
		seg_inc  = seg_sat ? CNT_MAX : cur.segment_count + 8'd1;
		cp_next  = {cur.codepoint[14:0], path_byte[5:0]};
		pend_dec = cur.pending - 2'd1;
		cp_bad   = (cur.seq_len == 2'd2 && cp_next < CP_MIN3)
			|| (cur.seq_len == 2'd3 && cp_next < CP_MIN4)
			|| (cp_next >= CP_SUR_LO && cp_next <= CP_SUR_HI)
			|| (cp_next > CP_MAX);
		count_plus = {1'b0, cur.byte_count} + (BYTE_CNT_W + 1)'(1);
	end

	always_comb begin
		nxt     = cur;
		verdict = 1'b0;
		if (path_byte == CHAR_NUL) begin
			verdict = !(cur.failed || cur.pending != 2'd0 || close_fail
				|| cur.byte_count == '0);
			nxt = PATH_STATE_CLEAR;
		end else begin
			if (count_plus >= (BYTE_CNT_W + 1)'(MAX_PATH))
				nxt.failed = 1'b1;
			if (cur.byte_count < BYTE_CNT_W'(MAX_PATH))
				nxt.byte_count = count_plus[BYTE_CNT_W-1:0];

			if (cur.pending != 2'd0) begin
				if (path_byte[7:6] != 2'b10) begin
					nxt.failed    = 1'b1;
					nxt.pending   = 2'd0;
					nxt.seq_len   = 2'd0;
					nxt.codepoint = '0;
				end else begin
					nxt.segment_count = seg_inc;
					if (seg_sat)
						nxt.failed = 1'b1;
					nxt.pending   = pend_dec;
					nxt.codepoint = cp_next;
					if (pend_dec == 2'd0) begin
						if (cp_bad)
							nxt.failed = 1'b1;
						nxt.seq_len   = 2'd0;
						nxt.codepoint = '0;
					end
				end
			end else if (path_byte == CHAR_SLASH) begin
				if (close_fail)
					nxt.failed = 1'b1;
				nxt.depth_count   = depth_inc;
				nxt.segment_count = 8'd0;
				nxt.dot_flags     = 2'b00;
			end else if (path_byte < CHAR_SPACE || path_byte == CHAR_DEL) begin
				nxt.failed = 1'b1;
			end else if (!path_byte[7]) begin
				if (path_byte == CHAR_DOT) begin
					if (cur.segment_count == 8'd0)
						nxt.dot_flags[0] = 1'b1;
					else if (cur.segment_count == 8'd1)
						nxt.dot_flags[1] = 1'b1;
				end
				nxt.segment_count = seg_inc;
				if (seg_sat)
					nxt.failed = 1'b1;
			end else if ((path_byte >= LEAD2_LO && path_byte <= LEAD2_HI)
				|| (path_byte >= LEAD3_LO && path_byte <= LEAD3_HI)
				|| (path_byte >= LEAD4_LO && path_byte <= LEAD4_HI)) begin
				// Valid lead byte: open a multi-byte sequence.
				if (path_byte <= LEAD2_HI) begin
					nxt.seq_len   = 2'd1;
					nxt.codepoint = {16'd0, path_byte[4:0]};
				end else if (path_byte >= LEAD3_LO && path_byte <= LEAD3_HI) begin
					nxt.seq_len   = 2'd2;
					nxt.codepoint = {17'd0, path_byte[3:0]};
				end else begin
					nxt.seq_len   = 2'd3;
					nxt.codepoint = {18'd0, path_byte[2:0]};
				end
				nxt.pending       = nxt.seq_len;
				nxt.segment_count = seg_inc;
				if (seg_sat)
					nxt.failed = 1'b1;
			end else begin
				nxt.failed = 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/path_utf8_validator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path UTF-8 validator core
// Checks slash-separated paths byte by byte and emits one verdict per path.
// ----------------------------------------------------------------------------
// Takes one path byte per cycle on the path channel unless the byte stage
// stalls. Each accepted byte is registered and the next path state is
// computed combinationally from it; a zero byte's verdict is registered in
// the verdict register. The byte stage stalls only when it holds a zero
// byte while an earlier verdict is still waiting to be taken. The user must
// write segment and depth limits through the APB port only while no path
// is in flight; the block does not enforce this.
module path_utf8_validator_core
	import puv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	puv_byte_if.sink          path,
	puv_verdict_if.source     verdict
);

	cfg_t        cfg;
	path_state_t state_q;
	path_state_t state_nxt;
	logic        verdict_nxt;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	logic        out_data_q;
	logic        is_end_s1;
	logic        advance;

	puv_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	puv_step u_step (
		.cfg       (cfg),
		.cur       (state_q),
		.path_byte (byte_s1),
		.nxt       (state_nxt),
		.verdict   (verdict_nxt)
	);

	// A terminator may only leave the byte stage when the verdict slot is free.
	assign is_end_s1  = (byte_s1 == CHAR_NUL);
	assign advance    = valid_s1 && (!is_end_s1 || !out_valid_q || verdict.ready);
	assign path.ready = !valid_s1 || advance;

	assign verdict.valid      = out_valid_q;
	assign verdict.path_valid = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (path.ready) begin
			valid_s1 <= path.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (path.ready && path.valid) begin
			byte_s1 <= path.path_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PATH_STATE_CLEAR;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_end_s1) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_end_s1) begin
			out_data_q <= verdict_nxt;
		end
	end

endmodule
